FILE: sv/open_addressing_hash_table_assert.svh
// Assertion macros for the hash table block
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define OAH_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define OAH_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define OAH_ASSERT_IMPL(label, clk, rst_n, a, c)
`define OAH_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: sv/oaht_pkg.sv
package oaht_pkg;
    localparam int unsigned DefSlots   = 64;
    localparam int unsigned QueueDepth = 2;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_USED  = 2'd1;
    localparam logic [1:0] KIND_TOMB  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [5:0] MaxUsedReset = 6'd48;

    // one accepted request, as it travels from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] hash;
        logic [63:0] value;
    } t_req;

    // one result item
    typedef struct packed {
        logic [1:0]  status;
        logic        is_new;
        logic [63:0] value;
    } t_rsp;
endpackage

FILE: sv/oaht_front.sv
// Request queue: accepts beats and holds them for the probe engine.
module oaht_front
    import oaht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_full,
    output logic o_valid,
    output t_req o_req,
    input  logic i_take
);
    t_req       r_mem [QueueDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'(QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];

    // store beats
    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_req;
        end
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_take && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push && !o_full) - 2'(i_take && o_valid);
        end
    end
endmodule

FILE: sv/oaht_back.sv
// Probe engine: walks slots, reading each (S_READ) and checking it (S_EVAL), then commits and reports.
module oaht_back
    import oaht_pkg::*;
#(
    parameter int unsigned SLOTS = DefSlots
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [5:0] i_max_used,
    input  logic       i_valid,
    input  t_req       i_req,
    output logic       o_take,
    output logic       o_busy,
    output logic       o_rsp_valid,
    output t_rsp       o_rsp,
    input  logic       i_rsp_take
);
    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned CW = AW + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EVAL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [1:0]  r_kind [SLOTS];
    logic [31:0] r_keym [SLOTS];
    logic [63:0] r_valm [SLOTS];

    logic [2:0]    r_state;
    t_req          r_req;
    logic [AW-1:0] r_idx, r_tomb, r_where;
    logic [CW-1:0] r_n, r_used;
    logic          r_have_tomb, r_hit, r_free, r_free_empty;
    logic [1:0]    r_rk;
    logic [31:0]   r_rkey;
    logic [63:0]   r_rval;
    logic          r_rsp_valid;
    t_rsp          r_rsp;

    logic [AW-1:0] n_idx;
    logic          w_en, w_keyen;
    logic [1:0]    w_kind;
    logic          w_room;

    assign n_idx       = r_idx + AW'(1);
    assign o_take      = (r_state == S_IDLE) && i_valid && !r_rsp_valid;
    assign o_busy      = (r_state != S_IDLE) || r_rsp_valid;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign w_room      = (r_used + CW'(1)) <= CW'(i_max_used);

    // decide the commit write
    always_comb begin
        w_en    = 1'b0;
        w_keyen = 1'b0;
        w_kind  = KIND_USED;
        if (r_state == S_DONE) begin
            if (r_req.op == OP_SET) begin
                if (r_hit) begin
                    w_en = 1'b1;
                end else if (r_free && (!r_free_empty || w_room)) begin
                    w_en = 1'b1;
                    w_keyen = 1'b1;
                end
            end else if (r_req.op == OP_DEL && r_hit) begin
                w_en = 1'b1;
                w_kind = KIND_TOMB;
            end
        end
    end

    // slot memories, registered read
    always_ff @(posedge i_clk) begin
        r_rkey <= r_keym[r_idx];
        r_rval <= r_valm[r_idx];
        if (w_en && (w_keyen || r_req.op == OP_SET)) begin
            r_valm[r_where] <= r_req.value;
        end
        if (w_keyen) begin
            r_keym[r_where] <= r_req.key;
        end
    end

    // kind array, cleared by a pass after reset
    always_ff @(posedge i_clk) begin
        r_rk <= r_kind[r_idx];
        if (r_state == S_CLEAR) begin
            r_kind[r_idx] <= KIND_EMPTY;
        end else if (w_en && (w_keyen || w_kind == KIND_TOMB)) begin
            r_kind[r_where] <= w_kind;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_used      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // raise the result after the commit, drop it once taken
            if (r_state == S_DONE) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_take && r_rsp_valid) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= n_idx;
                    if (r_idx == AW'(SLOTS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_take) begin
                        r_req        <= i_req;
                        r_idx        <= i_req.hash[AW-1:0];
                        r_n          <= '0;
                        r_have_tomb  <= 1'b0;
                        r_hit        <= 1'b0;
                        r_free       <= 1'b0;
                        r_free_empty <= 1'b0;
                        r_state      <= (i_req.op == OP_NOP) ? S_DONE : S_READ;
                    end
                end
                S_READ: r_state <= S_EVAL;
                S_EVAL: begin
                    r_idx <= n_idx;
                    r_n   <= r_n + CW'(1);
                    if (r_rk == KIND_EMPTY) begin
                        r_free       <= 1'b1;
                        r_free_empty <= !r_have_tomb;
                        r_where      <= r_have_tomb ? r_tomb : r_idx;
                        r_state      <= S_DONE;
                    end else if (r_rk == KIND_USED && r_rkey == r_req.key) begin
                        r_hit   <= 1'b1;
                        r_where <= r_idx;
                        r_state <= S_DONE;
                    end else begin
                        if (r_rk != KIND_USED && !r_have_tomb) begin
                            r_have_tomb <= 1'b1;
                            r_tomb      <= r_idx;
                        end
                        if (r_n == CW'(SLOTS - 1)) begin
                            r_free  <= r_have_tomb || r_rk != KIND_USED;
                            r_where <= r_have_tomb ? r_tomb : r_idx;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                    if (r_req.op == OP_GET && r_hit) begin
                        r_rsp <= '{status: ST_DONE, is_new: 1'b0, value: r_rval};
                    end else if (r_req.op == OP_SET) begin
                        r_rsp <= '{status: w_en ? ST_DONE : ST_FULL, is_new: w_keyen,
                                   value: 64'd0};
                        if (w_keyen && r_free_empty) r_used <= r_used + CW'(1);
                    end else if (r_req.op == OP_DEL && r_hit) begin
                        r_rsp <= '{status: ST_DONE, is_new: 1'b0, value: 64'd0};
                    end else begin
                        r_rsp <= '{status: ST_MISSING, is_new: 1'b0, value: 64'd0};
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: sv/open_addressing_hash_table.sv
// Open-addressing hash table, linear probing with tombstones.
// Input queue: drive i_operation, i_key_id, i_key_hash, i_value_in and
// raise push; a beat is taken on a clock edge where full is low.
// Result queue: while empty is low, o_status, o_is_new, o_value_out show
// the oldest result; raise pop to take it.
// Config: i_cfg_we with i_cfg_data writes max_used; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// A two-entry request queue feeds a probe engine that reads each slot from
// the slot memories (S_READ), checks it (S_EVAL) and moves on, then does the
// commit write (S_DONE); an unknown operation goes straight to S_DONE, and
// a walk visits at most SLOTS slots.
// The next item is taken in the cycle after the result is popped.
// One result is held at a time; while it is not popped the engine waits and
// the request queue fills, then full rises.
// After reset the engine sweeps the slot kinds to empty, one slot a cycle over
// all SLOTS slots, and takes no item meanwhile (beats still enter the queue).
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int unsigned SLOTS = DefSlots
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_key_id,
    input  logic [31:0] i_key_hash,
    input  logic [63:0] i_value_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic        o_is_new,
    output logic [63:0] o_value_out,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_data
);
`include "open_addressing_hash_table_assert.svh"
    t_req       w_req_in, w_req_q;
    logic       w_qvalid, w_take, w_busy, w_rvalid;
    t_rsp       w_rsp;
    logic [5:0] r_max_used;

    assign w_req_in = '{op: i_operation, key: i_key_id, hash: i_key_hash,
                        value: i_value_in};

    // hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_used <= MaxUsedReset;
        end else if (i_cfg_we) begin
            r_max_used <= i_cfg_data;
        end
    end

    oaht_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_req(w_req_in),
        .o_full(full), .o_valid(w_qvalid), .o_req(w_req_q), .i_take(w_take)
    );

    oaht_back #(.SLOTS(SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_used(r_max_used),
        .i_valid(w_qvalid), .i_req(w_req_q), .o_take(w_take), .o_busy(w_busy),
        .o_rsp_valid(w_rvalid), .o_rsp(w_rsp), .i_rsp_take(pop)
    );

    assign empty       = !w_rvalid;
    assign o_status    = w_rsp.status;
    assign o_is_new    = w_rsp.is_new;
    assign o_value_out = w_rsp.value;

    `OAH_ASSERT_IMPL(a_take_idle, i_clk, i_rst_n, w_take, w_qvalid && !w_rvalid)
    `OAH_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, w_take, w_busy)
    `OAH_ASSERT_IMPL(a_status_ok, i_clk, i_rst_n, !empty, o_status <= ST_FULL)
endmodule

FILE: tb/sv/tb_open_addressing_hash_table.sv
`timescale 1ns / 100ps

module tb_open_addressing_hash_table;
    import oaht_pkg::*;

    localparam int unsigned NSlots = DefSlots;
    localparam int unsigned DrainCycles = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [1:0]  i_operation;
    logic [31:0] i_key_id;
    logic [31:0] i_key_hash;
    logic [63:0] i_value_in;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic        o_is_new;
    logic [63:0] o_value_out;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_data;

    open_addressing_hash_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_key_id    (i_key_id),
        .i_key_hash  (i_key_hash),
        .i_value_in  (i_value_in),
        .empty       (empty),
        .pop         (pop),
        .o_status    (o_status),
        .o_is_new    (o_is_new),
        .o_value_out (o_value_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // shadow copy of the table
    logic [1:0]  shadow_kind [NSlots];
    logic [31:0] shadow_key [NSlots];
    logic [63:0] shadow_value [NSlots];
    int unsigned shadow_used;
    logic [5:0]  shadow_max_used;

    t_rsp        pending_rsp[$];
    int unsigned fail_count;
    int unsigned pop_gap;
    int unsigned pop_hold;
    bit          no_idle;

    // key pool for random traffic
    logic [31:0] pool_key [48];
    logic [31:0] pool_hash [48];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("tb_open_addressing_hash_table failed");
        $finish;
    end

    // apply one request to the shadow table, return the expected beat
    function automatic t_rsp table_apply(logic [1:0] op, logic [31:0] key,
                                         logic [31:0] hash, logic [63:0] val);
        t_rsp        r;
        int unsigned idx;
        int unsigned tomb;
        int unsigned where;
        bit          have_tomb;
        bit          hit;
        bit          have_free;
        bit          free_empty;
        r = '{status: ST_MISSING, is_new: 1'b0, value: 64'd0};
        if (op != OP_GET && op != OP_SET && op != OP_DEL)
            return r;
        idx = hash & (NSlots - 1);
        have_tomb = 0; hit = 0; have_free = 0; free_empty = 0;
        tomb = 0; where = 0;
        for (int n = 0; n < NSlots; n++) begin
            if (shadow_kind[idx] == KIND_EMPTY) begin
                have_free = 1;
                if (have_tomb) begin
                    where = tomb;
                end else begin
                    where = idx;
                    free_empty = 1;
                end
                break;
            end else if (shadow_kind[idx] == KIND_USED) begin
                if (shadow_key[idx] == key) begin
                    hit = 1;
                    where = idx;
                    break;
                end
            end else if (!have_tomb) begin
                have_tomb = 1;
                tomb = idx;
            end
            idx = (idx + 1) & (NSlots - 1);
        end
        if (!hit && !have_free && have_tomb) begin
            have_free = 1;
            where = tomb;
        end
        case (op)
            OP_GET: begin
                if (hit) begin
                    r.status = ST_DONE;
                    r.value = shadow_value[where];
                end
            end
            OP_SET: begin
                if (hit) begin
                    shadow_value[where] = val;
                    r.status = ST_DONE;
                end else if (!have_free) begin
                    r.status = ST_FULL;
                end else if (free_empty && shadow_used + 1 > shadow_max_used) begin
                    r.status = ST_FULL;
                end else begin
                    if (free_empty)
                        shadow_used++;
                    shadow_kind[where] = KIND_USED;
                    shadow_key[where] = key;
                    shadow_value[where] = val;
                    r.status = ST_DONE;
                    r.is_new = 1'b1;
                end
            end
            default: begin
                if (hit) begin
                    shadow_kind[where] = KIND_TOMB;
                    r.status = ST_DONE;
                end
            end
        endcase
        return r;
    endfunction

    // send one beat; called at a falling edge, returns at a falling edge
    task automatic send_request(logic [1:0] op, logic [31:0] key,
                                logic [31:0] hash, logic [63:0] val);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(15);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation <= op;
        i_key_id <= key;
        i_key_hash <= hash;
        i_value_in <= val;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        pending_rsp.push_back(table_apply(op, key, hash, val));
        @(negedge i_clk);
    endtask

    // stop sending and wait until every result is back
    task automatic drain_results();
        int unsigned t;
        push <= 1'b0;
        t = 0;
        while (pending_rsp.size() != 0 && t < 200000) begin
            @(negedge i_clk);
            t++;
        end
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic write_max_used(logic [5:0] limit);
        i_cfg_data <= limit;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        shadow_max_used = limit;
        @(negedge i_clk);
    endtask

    // receiver: hold off, idle or take a beat at each falling edge
    initial begin
        forever begin
            @(negedge i_clk);
            if (pop_hold > 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else if (pop_gap > 0) begin
                pop <= 1'b0;
                pop_gap--;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && pop && !empty) begin
            if (pending_rsp.size() == 0) begin
                $error("result beat with no request pending");
                fail_count++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                if (o_status !== exp_rsp.status) begin
                    $error("status: expected %0d, got %0d", exp_rsp.status, o_status);
                    fail_count++;
                end
                if (o_is_new !== exp_rsp.is_new) begin
                    $error("is_new: expected %0d, got %0d", exp_rsp.is_new, o_is_new);
                    fail_count++;
                end
                if (o_value_out !== exp_rsp.value) begin
                    $error("value_out: expected %h, got %h", exp_rsp.value, o_value_out);
                    fail_count++;
                end
            end
            pop_gap = no_idle ? 0 : $urandom_range(15);
        end
    end

    // hits, misses, overwrite, delete, tombstone reuse, unknown op
    task automatic test_basic_ops();
        send_request(OP_GET, 32'd0, 32'd0, 64'd0);
        send_request(OP_SET, 32'd0, 32'd0, 64'd0);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
        send_request(OP_SET, 32'h0000_0011, 32'h0000_0000, 64'h1234_5678_9ABC_DEF0);
        send_request(OP_SET, 32'h0000_0022, 32'h0000_0040, 64'h5555_AAAA_5555_AAAA);
        send_request(OP_GET, 32'h0000_0022, 32'h0000_0040, 64'd0);
        send_request(OP_SET, 32'h0000_0011, 32'h0000_0000, 64'hAAAA_5555_AAAA_5555);
        send_request(OP_GET, 32'h0000_0011, 32'h0000_0000, '1);
        send_request(OP_DEL, 32'h0000_0011, 32'h0000_0000, 64'd0);
        send_request(OP_GET, 32'h0000_0022, 32'h0000_0040, 64'd0);
        send_request(OP_GET, 32'h0000_0011, 32'h0000_0000, 64'd0);
        send_request(OP_DEL, 32'h0000_0011, 32'h0000_0000, 64'd0);
        send_request(OP_SET, 32'h0000_0033, 32'hFFFF_FFC0, 64'h0F0F_0F0F_0F0F_0F0F);
        send_request(OP_NOP, 32'h0000_0022, 32'h0000_0040, '1);
        send_request(OP_GET, 32'h0000_0033, 32'h0000_0000, 64'd0);
        send_request(OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'd0);
        drain_results();
    endtask

    // low limits refuse new slots but still allow overwrite and tombstone reuse
    task automatic test_limits();
        write_max_used(6'd1);
        send_request(OP_SET, 32'h0000_0044, 32'h0000_0005, 64'd7);
        send_request(OP_SET, 32'h0000_0022, 32'h0000_0040, 64'd9);
        send_request(OP_DEL, 32'h0000_0022, 32'h0000_0040, 64'd0);
        send_request(OP_SET, 32'h0000_0055, 32'h0000_0000, 64'd3);
        drain_results();
        write_max_used(6'd0);
        send_request(OP_SET, 32'h0000_0066, 32'h0000_0020, 64'd1);
        send_request(OP_SET, 32'h0000_0055, 32'h0000_0000, 64'd4);
        send_request(OP_GET, 32'h0000_0055, 32'h0000_0000, 64'd0);
        drain_results();
        write_max_used(6'd63);
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        no_idle = 1;
        pop_hold = 400;
        for (int i = 0; i < 24; i++)
            send_request(OP_SET, $urandom, $urandom, {$urandom, $urandom});
        no_idle = 0;
        drain_results();
    endtask

    // mostly pool keys with clustered hashes, some noise
    task automatic test_random_traffic(int unsigned count, logic [5:0] limit);
        int unsigned pick;
        int unsigned r;
        logic [1:0]  op;
        logic [31:0] key;
        logic [31:0] hash;
        write_max_used(limit);
        for (int i = 0; i < count; i++) begin
            if (i % 100 == 0)
                no_idle = ($urandom_range(3) == 0);
            r = $urandom_range(99);
            op = (r < 45) ? OP_SET : (r < 78) ? OP_GET : (r < 95) ? OP_DEL : OP_NOP;
            pick = $urandom_range(47);
            key = pool_key[pick];
            hash = pool_hash[pick];
            if ($urandom_range(9) == 0) begin
                key = $urandom;
                hash = $urandom;
            end
            send_request(op, key, hash, {$urandom, $urandom});
        end
        no_idle = 0;
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        i_operation = OP_GET;
        i_key_id = '0;
        i_key_hash = '0;
        i_value_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        fail_count = 0;
        pop_gap = 0;
        pop_hold = 0;
        no_idle = 0;
        for (int s = 0; s < NSlots; s++) begin
            shadow_kind[s] = KIND_EMPTY;
            shadow_key[s] = '0;
            shadow_value[s] = '0;
        end
        shadow_used = 0;
        shadow_max_used = MaxUsedReset;
        // a few hash bases so probe chains collide and wrap
        for (int k = 0; k < 48; k++) begin
            pool_key[k] = $urandom;
            pool_hash[k] = {$urandom} & 32'hFFFF_FFC0
                         | (($urandom_range(7) * 9 + 60) & (NSlots - 1));
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_basic_ops();
        test_limits();
        test_backpressure();
        test_random_traffic(600, 6'd63);
        test_random_traffic(550, 6'd40);
        test_random_traffic(600, 6'd63);

        if (fail_count == 0 && pending_rsp.size() == 0) begin
            $display("tb_open_addressing_hash_table passed");
        end else begin
            if (pending_rsp.size() != 0)
                $error("%0d results never arrived", pending_rsp.size());
            $display("tb_open_addressing_hash_table failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+sv
sv/oaht_pkg.sv
sv/oaht_front.sv
sv/oaht_back.sv
sv/open_addressing_hash_table.sv
tb/sv/tb_open_addressing_hash_table.sv
